/* sv/asort_pkg.sv */
// Shared constants and types of the ascending sorter.
package asort_pkg;

	localparam int DEF_MAX_KEYS  = 32;
	localparam int DEF_KEY_WIDTH = 32;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;  // place the new key, push larger keys one cell up
		logic shift;   // move every key one cell toward the head
	} chain_ctl_t;

endpackage

/* sv/asort_if.sv */
// Valid/ready channel interfaces for sorter input and output words.
interface asort_in_if #(
	parameter int KEY_WIDTH = 32
);
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] key_in;
	logic                 set_end;

	modport source (output valid, output key_in, output set_end, input ready);
	modport sink   (input valid, input key_in, input set_end, output ready);
endinterface

interface asort_out_if #(
	parameter int KEY_WIDTH = 32
);
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] key_out;
	logic                 run_end;
	logic                 overflow;

	modport source (output valid, output key_out, output run_end, output overflow,
		input ready);
	modport sink   (input valid, input key_out, input run_end, input overflow,
		output ready);
endinterface

/* sv/ascending_sorter_unit.sv */
// Top level of the ascending sorter: insertion chain plus drain control.
//
// Usage:
//   din carries one signed key per word, set_end marks the last key of a set.
//   dout returns the held set in ascending order, one key per word; run_end
//   marks the greatest key, overflow is set on every word of a set from which
//   keys were dropped because all MAX_KEYS cells were full.
// Throughput:
//   Keys enter at one per cycle; each lands in its sorted place the cycle it
//   is accepted, by a compare in every cell against the broadcast key.
//   The first sorted word is offered the cycle after the set_end word is
//   taken, then one word per cycle while dout.ready is high, as the chain
//   shifts toward its head. din.ready is low while the set drains.
// Stall:
//   When dout.ready is low the chain holds and the head word stays on dout.
// Reset:
//   arst_n clears all cell valid bits and the drain and overflow flags; the
//   block is empty and ready for a new set right after reset.
module ascending_sorter_unit
	import asort_pkg::*;
#(
	parameter int MAX_KEYS  = DEF_MAX_KEYS,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	asort_in_if.sink   din,
	asort_out_if.source dout
);

	logic                 drain_q;
	logic                 dropped_q;
	chain_ctl_t           ctl;
	logic                 in_acc;
	logic                 out_acc;
	logic                 full;
	logic [KEY_WIDTH-1:0] new_key;

	logic [MAX_KEYS-1:0]  gt_w;
	logic [MAX_KEYS-1:0]  valid_w;
	logic [KEY_WIDTH-1:0] key_w [MAX_KEYS];

	assign new_key    = din.key_in;
	assign din.ready  = !drain_q;
	assign in_acc     = din.valid && din.ready;
	assign full       = valid_w[MAX_KEYS-1];

	assign dout.valid    = drain_q && valid_w[0];
	assign dout.key_out  = key_w[0];
	assign dout.run_end  = !valid_w[1];
	assign dout.overflow = dropped_q;
	assign out_acc       = dout.valid && dout.ready;

	assign ctl.insert = in_acc && !full;
	assign ctl.shift  = out_acc;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic                 l_gt;
		logic                 l_valid;
		logic [KEY_WIDTH-1:0] l_key;
		logic                 r_valid;
		logic [KEY_WIDTH-1:0] r_key;

		if (i == 0) begin : g_head
			assign l_gt    = 1'b0;
			assign l_valid = 1'b0;
			assign l_key   = new_key;
		end else begin : g_mid
			assign l_gt    = gt_w[i-1];
			assign l_valid = valid_w[i-1];
			assign l_key   = key_w[i-1];
		end

		if (i == MAX_KEYS - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_key   = key_w[i];
		end else begin : g_body
			assign r_valid = valid_w[i+1];
			assign r_key   = key_w[i+1];
		end

		asort_cell #(
			.KEY_WIDTH (KEY_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_key     (new_key),
			.left_gt     (l_gt),
			.left_valid  (l_valid),
			.left_key    (l_key),
			.right_valid (r_valid),
			.right_key   (r_key),
			.gt          (gt_w[i]),
			.valid       (valid_w[i]),
			.key         (key_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (full) begin
					dropped_q <= 1'b1;
				end
				if (din.set_end) begin
					drain_q <= 1'b1;
				end
			end
			// last word of the set leaves: chain is empty again
			if (out_acc && !valid_w[1]) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/asort_cell.sv */
// One cell of the insertion chain: a key slot with its valid bit.
module asort_cell
	import asort_pkg::*;
#(
	parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chain_ctl_t           ctl,
	input  logic [KEY_WIDTH-1:0] new_key,
	input  logic                 left_gt,
	input  logic                 left_valid,
	input  logic [KEY_WIDTH-1:0] left_key,
	input  logic                 right_valid,
	input  logic [KEY_WIDTH-1:0] right_key,
	output logic                 gt,
	output logic                 valid,
	output logic [KEY_WIDTH-1:0] key
);

	logic                 valid_q;
	logic [KEY_WIDTH-1:0] key_q;

	// An empty slot counts as greater than anything.
	assign gt    = !valid_q || ($signed(key_q) > $signed(new_key));
	assign valid = valid_q;
	assign key   = key_q;

	// insert and shift never come in the same cycle; with neither the cell holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (ctl.insert) begin
				if (left_gt) begin
					valid_q <= left_valid;
				end else if (gt) begin
					valid_q <= 1'b1;
				end
			end else if (ctl.shift) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_gt) begin
				key_q <= left_key;
			end else if (gt) begin
				key_q <= new_key;
			end
		end else if (ctl.shift) begin
			key_q <= right_key;
		end
	end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the ascending sorter: random sets, stalls, overflow.
module tb_top;
	import asort_pkg::*;

	localparam int MAX_KEYS    = DEF_MAX_KEYS;
	localparam int KW          = DEF_KEY_WIDTH;
	localparam int HOLD_CYCLES = 200;
	localparam int STUCK_LIMIT = 5000;
	localparam int DRAIN_PAUSE = 8;

	typedef struct {
		logic [KW-1:0] key;
		logic          run_end;
		logic          overflow;
	} sorted_word_t;

	// Mirrors the store: keys collect until set_end, then the set is sorted into due.
	class sort_scoreboard;
		logic signed [KW-1:0] held[$];
		bit                   dropped;
		sorted_word_t         due[$];
		int                   errors;

		function void note_key(logic [KW-1:0] k, logic last);
			logic signed [KW-1:0] t;
			sorted_word_t w;
			int i, j;
			if (held.size() < MAX_KEYS) begin
				held.push_back(k);
			end else begin
				dropped = 1'b1;
			end
			if (!last) return;
			for (i = 1; i < held.size(); i++) begin
				t = held[i];
				j = i - 1;
				while (j >= 0 && held[j] > t) begin
					held[j+1] = held[j];
					j--;
				end
				held[j+1] = t;
			end
			for (i = 0; i < held.size(); i++) begin
				w.key      = held[i];
				w.run_end  = (i == held.size() - 1);
				w.overflow = dropped;
				due.push_back(w);
			end
			held.delete();
			dropped = 1'b0;
		endfunction

		function void check_word(logic [KW-1:0] k, logic re, logic ov);
			sorted_word_t want;
			if (due.size() == 0) begin
				$error("unexpected word: key_out=%0d", $signed(k));
				errors++;
				return;
			end
			want = due.pop_front();
			if (k !== want.key) begin
				$error("key_out: expected %0d, got %0d", $signed(want.key), $signed(k));
				errors++;
			end
			if (re !== want.run_end) begin
				$error("run_end: expected %0b, got %0b", want.run_end, re);
				errors++;
			end
			if (ov !== want.overflow) begin
				$error("overflow: expected %0b, got %0b", want.overflow, ov);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle;
	int   snk_idle;
	logic hold_go;
	int   words_sent;
	sort_scoreboard sb;

	asort_in_if  #(.KEY_WIDTH(KW)) din_if ();
	asort_out_if #(.KEY_WIDTH(KW)) dout_if ();

	ascending_sorter_unit #(
		.MAX_KEYS (MAX_KEYS),
		.KEY_WIDTH(KW)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: random ready, or a long hold-off each time hold_go toggles.
	initial begin
		logic hold_seen;
		int   hold_left;
		dout_if.ready = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (dout_if.valid && dout_if.ready)
			sb.check_word(dout_if.key_out, dout_if.run_end, dout_if.overflow);
	end

	// Ends the run if no word moves on either side for too long.
	initial begin
		int stuck;
		stuck = 0;
		forever begin
			@(posedge clk);
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
			if (stuck >= STUCK_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [KW-1:0] k, input logic last);
		din_if.valid   <= 1'b1;
		din_if.key_in  <= k;
		din_if.set_end <= last;
		do @(posedge clk); while (!din_if.ready);
		sb.note_key(k, last);
		words_sent++;
		if ($urandom_range(99) < src_idle) begin
			din_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
	endtask

	function automatic logic [KW-1:0] pick_key(logic [KW-1:0] prev);
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) return $urandom();
		if (sel < 75) return KW'($signed($urandom_range(6)) - 3);
		if (sel < 85) return $urandom_range(1) ? {1'b1, {(KW-1){1'b0}}} : {1'b0, {(KW-1){1'b1}}};
		return prev;
	endfunction

	task automatic send_set(input int n);
		logic [KW-1:0] k;
		int i;
		k = '0;
		for (i = 0; i < n; i++) begin
			k = pick_key(k);
			send_word(k, i == n - 1);
		end
	endtask

	// Mostly short sets; some near or past capacity, including a dropped set_end word.
	task automatic send_random_set();
		if ($urandom_range(99) < 12) begin
			send_set($urandom_range(MAX_KEYS + 4, MAX_KEYS - 1));
		end else begin
			send_set($urandom_range(8, 1));
		end
	endtask

	task automatic wait_drained();
		din_if.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	initial begin
		int ph;
		int stop_at;
		sb = new();
		arst_n         = 1'b0;
		din_if.valid   = 1'b0;
		din_if.key_in  = '0;
		din_if.set_end = 1'b0;
		hold_go        = 1'b0;
		src_idle       = 32;
		snk_idle       = 78;
		words_sent     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes as one-word sets, then mixed signs with duplicates
		send_word({1'b0, {(KW-1){1'b1}}}, 1'b1);
		send_word({1'b1, {(KW-1){1'b0}}}, 1'b1);
		send_word('0, 1'b1);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word({1'b0, {(KW-1){1'b1}}}, 1'b0);
		send_word({1'b1, {(KW-1){1'b0}}}, 1'b0);
		send_word(KW'(1), 1'b0);
		send_word('1, 1'b0);
		send_word({(KW/2){2'b01}}, 1'b0);
		send_word({(KW/2){2'b10}}, 1'b1);
		send_word(KW'(7), 1'b0);
		send_word(KW'(7), 1'b1);
		send_word(KW'(100), 1'b0);
		send_word(KW'(50), 1'b0);
		send_word(-KW'(50), 1'b0);
		send_word(-KW'(100), 1'b1);
		wait_drained();

		for (ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				// receiver stalls while an over-full set and the next one are offered
				src_idle <= 0;
				snk_idle <= 0;
				hold_go  <= ~hold_go;
				@(posedge clk);
				send_set(MAX_KEYS + 2);
				send_set(6);
				wait_drained();
			end
			src_idle <= (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
			snk_idle <= (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
			stop_at = words_sent + 80;
			while (words_sent < stop_at) send_random_set();
			wait_drained();
		end

		if (sb.due.size() != 0) sb.errors++;
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
